// ----- sv/aiss_pkg.sv -----
// Shared types, constants and command structs for the ADC smoother block.
// Used by every RTL file of the block but aiss_ram; depends on nothing.
`default_nettype none

package aiss_pkg;

   // Ring geometry and sample format
   localparam int RING_DEPTH = 16;
   localparam int SUM_FACTOR = 4;
   localparam int VAL_W      = 14;
   localparam int ADDR_W     = $clog2(RING_DEPTH);
   localparam int CNT_W      = $clog2(RING_DEPTH + 1);
   localparam int SUM_W      = VAL_W + $clog2(RING_DEPTH);
   localparam int FILL_W     = $clog2(2 * RING_DEPTH + 1);
   localparam int SD_W       = 5;

   localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};
   localparam int INIT_RAW = 2047 * SUM_FACTOR;
   localparam logic [VAL_W-1:0] INIT_VAL =
      (INIT_RAW > (2 ** VAL_W - 1)) ? VAL_MAX : VAL_W'(INIT_RAW);
   localparam logic [FILL_W-1:0] FILL_INIT = FILL_W'(2 * RING_DEPTH);

   // Q15 filter arithmetic
   localparam int COEF_W = 15;
   localparam int Q_SH   = 15;
   localparam int PROD_W = COEF_W + VAL_W;
   localparam int ACC_W  = VAL_W + 3;
   localparam logic [COEF_W-1:0] COEF_B0 = 15'd6554;
   localparam logic [COEF_W-1:0] COEF_B1 = 15'd13107;
   localparam logic [COEF_W-1:0] COEF_B2 = 15'd6554;
   localparam logic [COEF_W-1:0] COEF_A1 = 15'd0;
   localparam logic [COEF_W-1:0] COEF_A2 = 15'd6554;
   localparam int IIR_TERMS = 4;

   // Divider retires two quotient bits per step
   localparam int DIV_STEPS = VAL_W / 2;

   // Register map
   localparam int PADDR_W = 4;
   localparam int PDATA_W = 32;
   localparam logic [1:0] CSR_USE_IIR     = 2'd0;
   localparam logic [1:0] CSR_USE_STATS   = 2'd1;
   localparam logic [1:0] CSR_STATS_DEPTH = 2'd2;

   typedef enum logic [2:0] {
      TERM_B0_X   = 3'd0,
      TERM_B1_RAW = 3'd1,
      TERM_B2_RAW = 3'd2,
      TERM_A1_F1  = 3'd3,
      TERM_A2_F2  = 3'd4
   } term_type;

   typedef struct packed {
      logic            use_iir;
      logic            use_stats;
      logic [SD_W-1:0] stats_depth;
   } cfg_type;

   typedef struct packed {
      logic             take;
      logic             raw_we;
      logic             filt_we;
      logic             mac_clr;
      logic             mac_en;
      term_type         term;
      logic [CNT_W-1:0] rd_off;
      logic             scan_clr;
      logic             scan_en;
      logic             div_load;
      logic             div_step;
      logic             out_load;
   } cmd_type;

   typedef struct packed {
      logic [CNT_W-1:0] depth;
      logic             iir_on;
      logic             stats_on;
   } sts_type;

endpackage

`default_nettype wire

// ----- sv/adc_iir_smoother_with_window_stats_core.sv -----
// Top level of the single-channel ADC smoother with window statistics.
// Depends on aiss_pkg, aiss_ctrl, aiss_dp (and aiss_ram through aiss_dp).
//
// Usage:
//   req channel: one summed ADC sample per transfer (req_valid/req_ready).
//   rsp channel: one result per sample - filtered value, window min, max,
//   truncated mean, stats flag and buffers-full flag (rsp_valid/rsp_ready).
//   csr port: APB-style, pready tied high. use_iir at 0x0, use_stats at 0x4,
//   stats_depth at 0x8; paddr[1:0] is ignored, and 0xC reads zero and ignores writes.
//   Write configuration only while no sample is in flight.
// Sequence: the sample transfer, the ring write, then the filter terms and
//   filter write with the filter on, the window scan with statistics on
//   (one entry per ring read, then a 2-bit-per-cycle divider), and the
//   result load. One sample at a time: a new sample can be taken in the
//   cycle after the previous result is loaded.
// Stall: the result sits in an output register; the next sample is taken
//   while it waits, and the block holds in its final step until the
//   receiver drains the old result.
// Reset: synchronous, active high. Rings read as 2047 times the sum factor
//   until written, write position goes to zero, the fill countdown to
//   twice the ring depth, and registers to use_iir=0, use_stats=0,
//   stats_depth=16. No clearing pass is needed.
`default_nettype none

module adc_iir_smoother_with_window_stats_core (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // sample input
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [aiss_pkg::VAL_W-1:0]      req_sample,
   // result output
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic      [aiss_pkg::VAL_W-1:0]      rsp_filtered,
   output logic                                 rsp_stats_ok,
   output logic      [aiss_pkg::VAL_W-1:0]      rsp_window_min,
   output logic      [aiss_pkg::VAL_W-1:0]      rsp_window_max,
   output logic      [aiss_pkg::VAL_W-1:0]      rsp_window_avg,
   output logic                                 rsp_buffers_full,
   // configuration
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [aiss_pkg::PADDR_W-1:0]    csr_paddr,
   input  wire logic [aiss_pkg::PDATA_W-1:0]    csr_pwdata,
   output logic      [aiss_pkg::PDATA_W-1:0]    csr_prdata,
   output logic                                 csr_pready
);

   aiss_pkg::cfg_type cfg_ff;
   aiss_pkg::cmd_type cmd;
   aiss_pkg::sts_type sts;
   logic [1:0]        csr_idx;
   logic              csr_wr;

   // Register file: word index from the byte address
   assign csr_idx    = csr_paddr[3:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.use_iir     <= 1'b0;
         cfg_ff.use_stats   <= 1'b0;
         cfg_ff.stats_depth <= aiss_pkg::SD_W'(16);
      end else if (csr_wr) begin
         case (csr_idx)
            aiss_pkg::CSR_USE_IIR:     cfg_ff.use_iir     <= csr_pwdata[0];
            aiss_pkg::CSR_USE_STATS:   cfg_ff.use_stats   <= csr_pwdata[0];
            aiss_pkg::CSR_STATS_DEPTH: cfg_ff.stats_depth <= csr_pwdata[aiss_pkg::SD_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         aiss_pkg::CSR_USE_IIR:     csr_prdata = aiss_pkg::PDATA_W'(cfg_ff.use_iir);
         aiss_pkg::CSR_USE_STATS:   csr_prdata = aiss_pkg::PDATA_W'(cfg_ff.use_stats);
         aiss_pkg::CSR_STATS_DEPTH: csr_prdata = aiss_pkg::PDATA_W'(cfg_ff.stats_depth);
         default:                   csr_prdata = '0;
      endcase
   end

   // Sequencer: owns the handshakes and the step counter
   aiss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Datapath: rings, MAC, window scan, divider, result register
   aiss_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .cmd              (cmd),
      .sts              (sts),
      .req_sample       (req_sample),
      .rsp_filtered     (rsp_filtered),
      .rsp_stats_ok     (rsp_stats_ok),
      .rsp_window_min   (rsp_window_min),
      .rsp_window_max   (rsp_window_max),
      .rsp_window_avg   (rsp_window_avg),
      .rsp_buffers_full (rsp_buffers_full)
   );

endmodule

`default_nettype wire

// ----- sv/aiss_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package dependency.
`default_nettype none

module aiss_ram #(
   parameter int WIDTH = 14,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ----- sv/aiss_ctrl.sv -----
// Sequencer for the ADC smoother: walks write, filter, window scan and divide.
// Depends on aiss_pkg; drives aiss_dp through the command struct.
`default_nettype none

module aiss_ctrl (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   input  wire aiss_pkg::sts_type sts,
   output aiss_pkg::cmd_type    cmd
);

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_WRITE = 7'b0000010,
      S_IIR   = 7'b0000100,
      S_FWR   = 7'b0001000,
      S_SCAN  = 7'b0010000,
      S_DIV   = 7'b0100000,
      S_DONE  = 7'b1000000
   } state_type;

   state_type                  state_ff, state_in;
   logic [aiss_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic                       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.term  = aiss_pkg::TERM_B0_X;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.take = 1'b1;
               state_in = S_WRITE;
            end
         end
         S_WRITE: begin
            // store the sample, seed the filter sum, fetch the previous entry
            cmd.raw_we   = 1'b1;
            cmd.mac_clr  = 1'b1;
            cmd.term     = aiss_pkg::TERM_B0_X;
            cmd.rd_off   = aiss_pkg::CNT_W'(1);
            cmd.scan_clr = 1'b1;
            cnt_in       = '0;
            if (sts.iir_on) begin
               state_in = S_IIR;
            end else if (sts.stats_on) begin
               state_in = S_SCAN;
            end else begin
               state_in = S_DONE;
            end
         end
         S_IIR: begin
            cmd.rd_off = aiss_pkg::CNT_W'(2);
            cmd.mac_en = 1'b1;
            case (cnt_ff)
               aiss_pkg::CNT_W'(0): cmd.term = aiss_pkg::TERM_B1_RAW;
               aiss_pkg::CNT_W'(1): cmd.term = aiss_pkg::TERM_B2_RAW;
               aiss_pkg::CNT_W'(2): cmd.term = aiss_pkg::TERM_A1_F1;
               default:             cmd.term = aiss_pkg::TERM_A2_F2;
            endcase
            if (cnt_ff == aiss_pkg::CNT_W'(aiss_pkg::IIR_TERMS - 1)) begin
               cnt_in   = '0;
               state_in = S_FWR;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_FWR: begin
            cmd.filt_we = 1'b1;
            cnt_in      = '0;
            state_in    = sts.stats_on ? S_SCAN : S_DONE;
         end
         S_SCAN: begin
            // read one entry per cycle, fold in the entry from the previous read
            cmd.rd_off  = cnt_ff;
            cmd.scan_en = (cnt_ff != '0);
            if (cnt_ff == sts.depth) begin
               cnt_in   = '0;
               state_in = S_DIV;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_DIV: begin
            cmd.div_load = (cnt_ff == '0);
            cmd.div_step = (cnt_ff != '0);
            if (cnt_ff == aiss_pkg::CNT_W'(aiss_pkg::DIV_STEPS)) begin
               cnt_in   = '0;
               state_in = S_DONE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ----- sv/aiss_dp.sv -----
// Datapath of the ADC smoother: sample rings, Q15 MAC, window scan, divider.
// Depends on aiss_pkg and aiss_ram; driven by aiss_ctrl commands.
`default_nettype none

module aiss_dp (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire aiss_pkg::cfg_type           cfg,
   input  wire aiss_pkg::cmd_type           cmd,
   output aiss_pkg::sts_type                sts,
   input  wire logic [aiss_pkg::VAL_W-1:0]  req_sample,
   output logic      [aiss_pkg::VAL_W-1:0]  rsp_filtered,
   output logic                             rsp_stats_ok,
   output logic      [aiss_pkg::VAL_W-1:0]  rsp_window_min,
   output logic      [aiss_pkg::VAL_W-1:0]  rsp_window_max,
   output logic      [aiss_pkg::VAL_W-1:0]  rsp_window_avg,
   output logic                             rsp_buffers_full
);

   localparam int VW = aiss_pkg::VAL_W;
   localparam int AW = aiss_pkg::ADDR_W;
   localparam int CW = aiss_pkg::CNT_W;

   logic [VW-1:0]                    x_ff, y_ff, f1_ff, f2_ff;
   logic [AW-1:0]                    wp_ff;
   logic [aiss_pkg::FILL_W-1:0]      fill_ff;
   logic [aiss_pkg::ACC_W-1:0]       acc_ff, acc_in;
   logic [aiss_pkg::RING_DEPTH-1:0]  raw_vld_ff, filt_vld_ff;
   logic                             raw_rv_ff, filt_rv_ff;
   logic [aiss_pkg::SUM_W-1:0]       sum_ff;
   logic [VW-1:0]                    mn_ff, mx_ff;
   logic [CW-1:0]                    rem_ff, rem_in;
   logic [VW-1:0]                    quo_ff, quo_in;

   logic [VW-1:0]                    raw_q, filt_q, raw_val, filt_val, scan_val;
   logic [VW-1:0]                    y_sat;
   logic [AW-1:0]                    rd_addr;
   logic [CW:0]                      addr_sum;
   logic [CW-1:0]                    depth;
   logic [aiss_pkg::COEF_W-1:0]      coef;
   logic [VW-1:0]                    opnd;
   logic [aiss_pkg::PROD_W-1:0]      prod;
   logic [VW-1:0]                    term_val;

   // Ring storage
   aiss_ram #(.WIDTH(VW), .DEPTH(aiss_pkg::RING_DEPTH)) u_raw_ram (
      .clock (clock),
      .we    (cmd.raw_we),
      .waddr (wp_ff),
      .wdata (x_ff),
      .raddr (rd_addr),
      .rdata (raw_q)
   );

   aiss_ram #(.WIDTH(VW), .DEPTH(aiss_pkg::RING_DEPTH)) u_filt_ram (
      .clock (clock),
      .we    (cmd.filt_we),
      .waddr (wp_ff),
      .wdata (y_sat),
      .raddr (rd_addr),
      .rdata (filt_q)
   );

   // Read address: write position plus offset, wrapped once
   always_comb begin
      addr_sum = (CW + 1)'(wp_ff) + (CW + 1)'(cmd.rd_off);
      if (addr_sum >= (CW + 1)'(aiss_pkg::RING_DEPTH)) begin
         addr_sum = addr_sum - (CW + 1)'(aiss_pkg::RING_DEPTH);
      end
      rd_addr = addr_sum[AW-1:0];
   end

   // Entries never written read as the reset fill value
   assign raw_val  = raw_rv_ff  ? raw_q  : aiss_pkg::INIT_VAL;
   assign filt_val = filt_rv_ff ? filt_q : aiss_pkg::INIT_VAL;
   assign scan_val = cfg.use_iir ? filt_val : raw_val;

   // Window length, clamped to 1..RING_DEPTH
   always_comb begin
      if (cfg.stats_depth == '0) begin
         depth = CW'(1);
      end else if (int'(cfg.stats_depth) > aiss_pkg::RING_DEPTH) begin
         depth = CW'(aiss_pkg::RING_DEPTH);
      end else begin
         depth = CW'(cfg.stats_depth);
      end
   end

   assign sts.depth    = depth;
   assign sts.iir_on   = cfg.use_iir;
   assign sts.stats_on = cfg.use_stats;

   // One Q15 product per cycle, truncated before the sum
   always_comb begin
      case (cmd.term)
         aiss_pkg::TERM_B0_X:   begin coef = aiss_pkg::COEF_B0; opnd = x_ff;    end
         aiss_pkg::TERM_B1_RAW: begin coef = aiss_pkg::COEF_B1; opnd = raw_val; end
         aiss_pkg::TERM_B2_RAW: begin coef = aiss_pkg::COEF_B2; opnd = raw_val; end
         aiss_pkg::TERM_A1_F1:  begin coef = aiss_pkg::COEF_A1; opnd = f1_ff;   end
         aiss_pkg::TERM_A2_F2:  begin coef = aiss_pkg::COEF_A2; opnd = f2_ff;   end
         default:               begin coef = '0;                opnd = '0;      end
      endcase
      prod     = aiss_pkg::PROD_W'(coef) * aiss_pkg::PROD_W'(opnd);
      term_val = prod[aiss_pkg::PROD_W-1:aiss_pkg::Q_SH];
   end

   always_comb begin
      if (cmd.mac_clr) begin
         acc_in = aiss_pkg::ACC_W'(term_val);
      end else if (cmd.mac_en) begin
         acc_in = acc_ff + aiss_pkg::ACC_W'(term_val);
      end else begin
         acc_in = acc_ff;
      end
   end

   assign y_sat = (acc_ff > aiss_pkg::ACC_W'(aiss_pkg::VAL_MAX)) ?
                  aiss_pkg::VAL_MAX : acc_ff[VW-1:0];

   // Restoring divide, two quotient bits per step
   always_comb begin
      logic [CW:0] trial;
      trial  = '0;
      rem_in = rem_ff;
      quo_in = quo_ff;
      if (cmd.div_load) begin
         rem_in = CW'(sum_ff[aiss_pkg::SUM_W-1:VW]);
         quo_in = sum_ff[VW-1:0];
      end else if (cmd.div_step) begin
         for (int i = 0; i < 2; i++) begin
            trial = {rem_in, quo_in[VW-1]};
            if (trial >= (CW + 1)'(depth)) begin
               trial  = trial - (CW + 1)'(depth);
               quo_in = {quo_in[VW-2:0], 1'b1};
            end else begin
               quo_in = {quo_in[VW-2:0], 1'b0};
            end
            rem_in = trial[CW-1:0];
         end
      end
   end

   // Control state: write position, fill countdown, entry valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff       <= '0;
         fill_ff     <= aiss_pkg::FILL_INIT;
         raw_vld_ff  <= '0;
         filt_vld_ff <= '0;
      end else begin
         if (cmd.take) begin
            wp_ff <= (wp_ff == '0) ? AW'(aiss_pkg::RING_DEPTH - 1) : wp_ff - 1'b1;
            if (fill_ff != '0) begin
               fill_ff <= fill_ff - 1'b1;
            end
         end
         if (cmd.raw_we) begin
            raw_vld_ff[wp_ff] <= 1'b1;
         end
         if (cmd.filt_we) begin
            filt_vld_ff[wp_ff] <= 1'b1;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      raw_rv_ff  <= raw_vld_ff[rd_addr];
      filt_rv_ff <= filt_vld_ff[rd_addr];
      acc_ff     <= acc_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      if (cmd.take) begin
         x_ff <= req_sample;
         y_ff <= req_sample;
      end
      if (cmd.filt_we) begin
         y_ff <= y_sat;
      end
      if (cmd.mac_en && cmd.term == aiss_pkg::TERM_B1_RAW) begin
         f1_ff <= filt_val;
      end
      if (cmd.mac_en && cmd.term == aiss_pkg::TERM_B2_RAW) begin
         f2_ff <= filt_val;
      end
      if (cmd.scan_clr) begin
         sum_ff <= '0;
         mn_ff  <= aiss_pkg::VAL_MAX;
         mx_ff  <= '0;
      end else if (cmd.scan_en) begin
         sum_ff <= sum_ff + aiss_pkg::SUM_W'(scan_val);
         if (scan_val < mn_ff) begin
            mn_ff <= scan_val;
         end
         if (scan_val > mx_ff) begin
            mx_ff <= scan_val;
         end
      end
      if (cmd.out_load) begin
         rsp_filtered     <= y_ff;
         rsp_stats_ok     <= cfg.use_stats;
         rsp_window_min   <= cfg.use_stats ? mn_ff  : '0;
         rsp_window_max   <= cfg.use_stats ? mx_ff  : '0;
         rsp_window_avg   <= cfg.use_stats ? quo_ff : '0;
         rsp_buffers_full <= (fill_ff == '0);
      end
   end

endmodule

`default_nettype wire

// ----- sv/aiss_chk.sv -----
// Port-level checker for the ADC smoother, bound to the top level.
// Depends on aiss_pkg for widths.
`default_nettype none

module aiss_chk (
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       req_valid,
   input wire logic                       req_ready,
   input wire logic                       rsp_valid,
   input wire logic                       rsp_ready,
   input wire logic [aiss_pkg::VAL_W-1:0] rsp_filtered,
   input wire logic                       rsp_stats_ok,
   input wire logic [aiss_pkg::VAL_W-1:0] rsp_window_min,
   input wire logic [aiss_pkg::VAL_W-1:0] rsp_window_max,
   input wire logic [aiss_pkg::VAL_W-1:0] rsp_window_avg
);

   // Stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_filtered))
      else $error("result changed while stalled");

   // Disabled stats report zeros
   a_stats_off: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stats_ok |->
         rsp_window_min == '0 && rsp_window_max == '0 && rsp_window_avg == '0)
      else $error("stats fields nonzero while disabled");

   // Mean lies between minimum and maximum
   a_stats_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stats_ok |->
         rsp_window_min <= rsp_window_avg && rsp_window_avg <= rsp_window_max)
      else $error("window mean outside min..max");

   // A result never appears the cycle after a sample transfer
   a_no_early: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$rose(rsp_valid))
      else $error("result too early");

endmodule

bind adc_iir_smoother_with_window_stats_core aiss_chk u_aiss_chk (.*);

`default_nettype wire
